// ----- rtl/i2f_pkg.sv -----
// Shared types and constants for the int32 to float32 converter.
`timescale 1ns / 1ps
package i2f_pkg;
  localparam int unsigned DataW = 32;
  localparam int unsigned FracW = 23;
  localparam int unsigned ExpW = 8;
  localparam int unsigned PosW = 5;
  localparam logic [ExpW-1:0] ExpBias = 8'd127;
  localparam logic [7:0] RoundHalf = 8'd128;

  // Sign and magnitude after the first stage
  typedef struct packed {
    logic             sign;
    logic [DataW-1:0] mag;
  } mag_t;

  // Normalized word after the shift stage
  typedef struct packed {
    logic             sign;
    logic             zero;
    logic [PosW-1:0]  top;
    logic [DataW-1:0] norm;
  } norm_t;
endpackage

// ----- rtl/int32_to_float32_convert.sv -----
// Top level: pipelined signed int32 to IEEE single converter.
`timescale 1ns / 1ps
// Converts a two's complement 32-bit integer to the nearest single-precision
// value, round to nearest, ties to even. Three register stages: negate,
// leading-one search with normalizing shift, then round and pack. One beat
// enters per cycle unless the output stalls, and a stall at the output holds
// every stage without loss. No reset sweep.
module int32_to_float32_convert (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] integer_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] float_bits_o
);
  logic s1_valid_q, s2_valid_q, s3_valid_q;
  logic s1_en, s2_en, s3_en;
  i2f_pkg::mag_t  s1_q, s1_d;
  i2f_pkg::norm_t s2_q, s2_d;
  logic [31:0] s3_q, s3_d;
  logic [4:0] top;

  // Stall chain: a stage moves when its successor can take it
  assign s3_en = !s3_valid_q || out_ready_i;
  assign s2_en = !s2_valid_q || s3_en;
  assign s1_en = !s1_valid_q || s2_en;
  assign in_ready_o = s1_en;

  // Stage 1: sign split and negate
  always_comb begin
    s1_d.sign = integer_value_i[31];
    s1_d.mag  = integer_value_i[31] ? (32'd0 - integer_value_i) : integer_value_i;
  end

  // Stage 2: find leading one and normalize
  i2f_lzc u_lzc (.word_i(s1_q.mag), .top_o(top));
  always_comb begin
    s2_d.sign = s1_q.sign;
    s2_d.zero = (s1_q.mag == 32'd0);
    s2_d.top  = top;
    s2_d.norm = s1_q.mag << (5'd31 - top);
  end

  // Stage 3: round to nearest even and pack
  always_comb begin
    logic [i2f_pkg::FracW-1:0] frac;
    logic [7:0]  low;
    logic        up;
    logic [23:0] sum;
    logic [7:0]  expo;
    frac = s2_q.norm[30:8];
    low  = s2_q.norm[7:0];
    up   = (low > i2f_pkg::RoundHalf) || (low == i2f_pkg::RoundHalf && frac[0]);
    sum  = {1'b0, frac} + {23'd0, up};
    expo = {3'd0, s2_q.top} + i2f_pkg::ExpBias + {7'd0, sum[23]};
    s3_d = s2_q.zero ? 32'd0 : {s2_q.sign, expo, sum[22:0]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      if (s1_en) s1_valid_q <= in_valid_i;
      if (s2_en) s2_valid_q <= s1_valid_q;
      if (s3_en) s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_en) s1_q <= s1_d;
    if (s2_en) s2_q <= s2_d;
    if (s3_en) s3_q <= s3_d;
  end

  assign out_valid_o  = s3_valid_q;
  assign float_bits_o = s3_q;

`ifndef SYNTHESIS
  // A stalled output beat keeps its value
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(float_bits_o))
    else $error("output beat changed under stall");
  // An accepted beat reaches the output when the output is never stalled
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o ##1 out_ready_i ##1 out_ready_i |=> out_valid_o)
    else $error("beat lost in pipeline");
  // Exponent never hits the infinity code
  a_exp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> float_bits_o[30:23] != 8'hff)
    else $error("exponent overflow");
`endif
endmodule

// ----- rtl/i2f_lzc.sv -----
// Leading-one position of a 32-bit word, found as a tree of small encoders.
`timescale 1ns / 1ps
module i2f_lzc (
  input  logic [31:0] word_i,
  output logic [4:0]  top_o
);
  logic [3:0] grp_hit;
  logic [2:0] grp_pos [4];
  logic [1:0] grp_sel;

  // Per-byte leading one
  always_comb begin
    for (int g = 0; g < 4; g++) begin
      grp_hit[g] = |word_i[g*8 +: 8];
      grp_pos[g] = 3'd0;
      for (int b = 0; b < 8; b++) begin
        if (word_i[g*8 + b]) grp_pos[g] = 3'(b);
      end
    end
  end

  // Highest byte with a one
  always_comb begin
    grp_sel = 2'd0;
    for (int g = 0; g < 4; g++) begin
      if (grp_hit[g]) grp_sel = 2'(g);
    end
  end

  assign top_o = {grp_sel, grp_pos[grp_sel]};
endmodule

// ----- verif/tb.sv -----
// Testbench for the int32 to float32 converter: random and directed beats.
`timescale 1ns / 1ps
module tb;
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [31:0] integer_value_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] float_bits_o;

  typedef logic [31:0] word_t;

  word_t pending_ints[$];
  word_t expected_floats[$];
  int    send_idle_pct = 0;
  int    recv_stall_pct = 0;
  bit    hold_off = 1'b0;
  int    errors = 0;
  int    beats_in = 0;
  int    beats_out = 0;
  longint cycles = 0;

  int32_to_float32_convert i_dut (.*);

  always #4 clk_i = ~clk_i;

  // Nearest single value of a signed int, ties to even
  function automatic word_t int_to_single(word_t v);
    logic        sgn;
    word_t       mag;
    word_t       norm;
    logic [23:0] frac;
    logic [7:0]  low;
    logic [7:0]  expo;
    int          top;
    sgn = v[31];
    mag = sgn ? (~v + 32'd1) : v;
    if (mag == '0) return '0;
    top = 31;
    while (!mag[top]) top--;
    expo = 8'(top + 127);
    norm = mag << (31 - top);
    frac = {1'b0, norm[30:8]};
    low = norm[7:0];
    if (low > 8'd128 || (low == 8'd128 && frac[0])) frac = frac + 24'd1;
    if (frac[23]) begin
      frac[23] = 1'b0;
      expo = expo + 8'd1;
    end
    return {sgn, expo, frac[22:0]};
  endfunction

  // Driver: offer the next int, hold until accepted
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        expected_floats.push_back(int_to_single(integer_value_i));
        beats_in <= beats_in + 1;
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_ints.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          integer_value_i <= pending_ints.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_ready_i <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: compare each output beat with the oldest expectation
  always @(posedge clk_i) begin
    word_t exp_f;
    if (rst_ni && out_valid_o && out_ready_i) begin
      beats_out <= beats_out + 1;
      if (expected_floats.size() == 0) begin
        $error("float_bits: unexpected beat, actual %08h", float_bits_o);
        errors++;
      end else begin
        exp_f = expected_floats.pop_front();
        if (float_bits_o !== exp_f) begin
          $error("float_bits: expected %08h actual %08h", exp_f, float_bits_o);
          errors++;
        end
      end
    end
  end

  // Timeout
  always @(posedge clk_i) begin
    if (cycles > 400000) begin
      $display("int32_to_float32_convert regression: fail");
      $finish;
    end
  end

  task automatic drain_phase();
    while (pending_ints.size() > 0 || in_valid_i) @(posedge clk_i);
  endtask

  task automatic add_random(int n);
    word_t v;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(3))
        0: v = $urandom();
        1: v = $urandom() >> $urandom_range(31);
        2: v = -($urandom() >> $urandom_range(31));
        default: v = ($urandom() >> $urandom_range(31)) | 32'hff;
      endcase
      pending_ints.push_back(v);
    end
  endtask

  initial begin
    word_t directed[$];
    directed = {32'h0, 32'h1, 32'hffffffff, 32'h7fffffff, 32'h80000000,
                32'h80000001, 32'h00ffffff, 32'h01000000, 32'h01000001,
                32'h01000003, 32'h02000002, 32'h02000006, 32'h0100000f,
                32'hfeffffff, 32'hfefffffd, 32'h7fffff80, 32'h7fffffc0,
                32'h55555555, 32'haaaaaaaa, 32'h00800000, 32'h12345678};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    foreach (directed[i]) pending_ints.push_back(directed[i]);
    add_random(200);
    drain_phase();
    send_idle_pct = 82;
    add_random(200);
    drain_phase();
    send_idle_pct = 0;
    recv_stall_pct = 82;
    add_random(200);
    drain_phase();
    // Long receiver hold-off while the sender keeps offering
    recv_stall_pct = 0;
    hold_off = 1'b1;
    add_random(100);
    repeat (60) @(posedge clk_i);
    hold_off = 1'b0;
    drain_phase();
    send_idle_pct = 17;
    recv_stall_pct = 17;
    add_random(330);
    drain_phase();
    while (expected_floats.size() > 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (expected_floats.size() != 0) begin
      $error("float_bits: %0d expected beats never arrived", expected_floats.size());
      errors++;
    end
    $display("Converted %0d ints, checked %0d floats, incl. rounding ties,", beats_in,
             beats_out);
    $display("most negative int, zero, and idle, stall and back-pressure phases.");
    if (errors == 0) begin
      $display("int32_to_float32_convert regression: pass");
    end else begin
      $display("int32_to_float32_convert regression: fail");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
rtl/i2f_pkg.sv
rtl/i2f_lzc.sv
rtl/int32_to_float32_convert.sv
verif/tb.sv
